/* rtl/ps2kd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, scancode constants and ASCII ROM functions for the PS/2 set-2 key decoder.
// No dependencies.
package ps2kd_pkg;

	localparam logic [7:0] KEY_NONE   = 8'h00;
	localparam logic [7:0] KEY_EXT    = 8'hE0;
	localparam logic [7:0] KEY_BRK    = 8'hF0;
	localparam logic [7:0] KEY_ALT    = 8'h11;
	localparam logic [7:0] KEY_LSHIFT = 8'h12;
	localparam logic [7:0] KEY_CTRL   = 8'h14;
	localparam logic [7:0] KEY_CAPS   = 8'h58;
	localparam logic [7:0] KEY_RSHIFT = 8'h59;
	localparam logic [7:0] KEY_NUM    = 8'h77;

	localparam int MB_CAPS   = 0;
	localparam int MB_LSHIFT = 1;
	localparam int MB_RSHIFT = 2;
	localparam int MB_LCTRL  = 3;
	localparam int MB_RCTRL  = 4;
	localparam int MB_LALT   = 5;
	localparam int MB_RALT   = 6;
	localparam int MB_NUM    = 7;

	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] make_key;
		logic [7:0] break_key;
	} item_t;

	function automatic logic [7:0] keypad_rom(input logic [7:0] code);
		logic [7:0] ch;
		unique case (code)
			8'h69: ch = 8'h31;
			8'h6B: ch = 8'h34;
			8'h6C: ch = 8'h37;
			8'h70: ch = 8'h30;
			8'h71: ch = 8'h2E;
			8'h72: ch = 8'h32;
			8'h73: ch = 8'h35;
			8'h74: ch = 8'h36;
			8'h75: ch = 8'h38;
			8'h79: ch = 8'h2B;
			8'h7A: ch = 8'h33;
			8'h7B: ch = 8'h2D;
			8'h7C: ch = 8'h2A;
			8'h7D: ch = 8'h39;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] lower_rom(input logic [7:0] code);
		logic [7:0] ch;
		unique case (code)
			8'h0E: ch = 8'h60;
			8'h15: ch = 8'h71;
			8'h16: ch = 8'h31;
			8'h1A: ch = 8'h7A;
			8'h1B: ch = 8'h73;
			8'h1C: ch = 8'h61;
			8'h1D: ch = 8'h77;
			8'h1E: ch = 8'h32;
			8'h21: ch = 8'h63;
			8'h22: ch = 8'h78;
			8'h23: ch = 8'h64;
			8'h24: ch = 8'h65;
			8'h25: ch = 8'h34;
			8'h26: ch = 8'h33;
			8'h29: ch = 8'h20;
			8'h2A: ch = 8'h76;
			8'h2B: ch = 8'h66;
			8'h2C: ch = 8'h74;
			8'h2D: ch = 8'h72;
			8'h2E: ch = 8'h35;
			8'h31: ch = 8'h6E;
			8'h32: ch = 8'h62;
			8'h33: ch = 8'h68;
			8'h34: ch = 8'h67;
			8'h35: ch = 8'h79;
			8'h36: ch = 8'h36;
			8'h3A: ch = 8'h6D;
			8'h3B: ch = 8'h6A;
			8'h3C: ch = 8'h75;
			8'h3D: ch = 8'h37;
			8'h3E: ch = 8'h38;
			8'h41: ch = 8'h2C;
			8'h42: ch = 8'h6B;
			8'h43: ch = 8'h69;
			8'h44: ch = 8'h6F;
			8'h45: ch = 8'h30;
			8'h46: ch = 8'h39;
			8'h49: ch = 8'h2E;
			8'h4A: ch = 8'h2F;
			8'h4B: ch = 8'h6C;
			8'h4C: ch = 8'h3B;
			8'h4D: ch = 8'h70;
			8'h4E: ch = 8'h2D;
			8'h52: ch = 8'h27;
			8'h54: ch = 8'h5B;
			8'h55: ch = 8'h3D;
			8'h5B: ch = 8'h5D;
			8'h5D: ch = 8'h5C;
			default: ch = keypad_rom(code);
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] upper_rom(input logic [7:0] code);
		logic [7:0] ch;
		unique case (code)
			8'h0E: ch = 8'h7E;
			8'h15: ch = 8'h51;
			8'h16: ch = 8'h21;
			8'h1A: ch = 8'h5A;
			8'h1B: ch = 8'h53;
			8'h1C: ch = 8'h41;
			8'h1D: ch = 8'h57;
			8'h1E: ch = 8'h40;
			8'h21: ch = 8'h43;
			8'h22: ch = 8'h58;
			8'h23: ch = 8'h44;
			8'h24: ch = 8'h45;
			8'h25: ch = 8'h24;
			8'h26: ch = 8'h23;
			8'h29: ch = 8'h20;
			8'h2A: ch = 8'h56;
			8'h2B: ch = 8'h46;
			8'h2C: ch = 8'h54;
			8'h2D: ch = 8'h52;
			8'h2E: ch = 8'h25;
			8'h31: ch = 8'h4E;
			8'h32: ch = 8'h42;
			8'h33: ch = 8'h48;
			8'h34: ch = 8'h47;
			8'h35: ch = 8'h59;
			8'h36: ch = 8'h5E;
			8'h3A: ch = 8'h4D;
			8'h3B: ch = 8'h4A;
			8'h3C: ch = 8'h55;
			8'h3D: ch = 8'h26;
			8'h3E: ch = 8'h2A;
			8'h41: ch = 8'h3C;
			8'h42: ch = 8'h4B;
			8'h43: ch = 8'h49;
			8'h44: ch = 8'h4F;
			8'h45: ch = 8'h29;
			8'h46: ch = 8'h28;
			8'h49: ch = 8'h3E;
			8'h4A: ch = 8'h3F;
			8'h4B: ch = 8'h4C;
			8'h4C: ch = 8'h3A;
			8'h4D: ch = 8'h50;
			8'h4E: ch = 8'h5F;
			8'h52: ch = 8'h22;
			8'h54: ch = 8'h7B;
			8'h55: ch = 8'h2B;
			8'h5B: ch = 8'h7D;
			8'h5D: ch = 8'h7C;
			default: ch = keypad_rom(code);
		endcase
		return ch;
	endfunction

endpackage

/* rtl/ps2kd_front.sv */
`timescale 1ns / 1ps
// Front end: accepts scancode bytes and classifies them into make and break codes.
// Depends on ps2kd_pkg.
module ps2kd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        scan_byte,
	input  logic              q_full,
	output logic              push,
	output ps2kd_pkg::item_t  push_item
);

	logic [7:0] prior_q;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_item.make_key  = ps2kd_pkg::KEY_NONE;
		push_item.break_key = ps2kd_pkg::KEY_NONE;
		if (prior_q == ps2kd_pkg::KEY_BRK) begin
			push_item.break_key = scan_byte;
		end else if (scan_byte != ps2kd_pkg::KEY_NONE && scan_byte != ps2kd_pkg::KEY_EXT &&
				scan_byte != ps2kd_pkg::KEY_BRK) begin
			push_item.make_key = scan_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q <= 8'h00;
		end else if (push) begin
			prior_q <= scan_byte;
		end
	end

endmodule

/* rtl/ps2kd_queue.sv */
`timescale 1ns / 1ps
// Short item queue between the classifier and the modifier/ASCII back end.
// Depends on ps2kd_pkg.
module ps2kd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ps2kd_pkg::item_t  push_item,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output ps2kd_pkg::item_t  head
);

	ps2kd_pkg::item_t              slot_q [ps2kd_pkg::QDEPTH];
	logic [ps2kd_pkg::QAW-1:0]     wr_ptr_q;
	logic [ps2kd_pkg::QAW-1:0]     rd_ptr_q;
	logic [ps2kd_pkg::QCW-1:0]     count_q;

	localparam logic [ps2kd_pkg::QAW-1:0] LAST = ps2kd_pkg::QAW'(ps2kd_pkg::QDEPTH - 1);
	localparam logic [ps2kd_pkg::QCW-1:0] FULL_CNT = ps2kd_pkg::QCW'(ps2kd_pkg::QDEPTH);

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/ps2kd_back.sv */
`timescale 1ns / 1ps
// Back end: updates the modifier flags, looks up ASCII and holds the result register.
// Depends on ps2kd_pkg.
module ps2kd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  ps2kd_pkg::item_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        make_key,
	output logic [7:0]        break_key,
	output logic [7:0]        ascii_char,
	output logic [7:0]        modifier_flags
);

	logic [7:0] mods_q;
	logic [7:0] mods_nxt;
	logic [7:0] mk;
	logic [7:0] bk;
	logic [7:0] ch;
	logic       upper;
	logic       valid_q;
	logic [7:0] make_q;
	logic [7:0] break_q;
	logic [7:0] ascii_q;
	logic [7:0] flags_q;

	assign mk  = head.make_key;
	assign bk  = head.break_key;
	assign pop = !q_empty && (!valid_q || !out_stall);

	always_comb begin
		mods_nxt = mods_q;
		if (mk == ps2kd_pkg::KEY_ALT) begin
			mods_nxt[ps2kd_pkg::MB_LALT] = 1'b1;
			mods_nxt[ps2kd_pkg::MB_RALT] = 1'b1;
		end
		if (bk == ps2kd_pkg::KEY_ALT) begin
			mods_nxt[ps2kd_pkg::MB_LALT] = 1'b0;
			mods_nxt[ps2kd_pkg::MB_RALT] = 1'b0;
		end
		if (mk == ps2kd_pkg::KEY_LSHIFT) mods_nxt[ps2kd_pkg::MB_LSHIFT] = 1'b1;
		if (bk == ps2kd_pkg::KEY_LSHIFT) mods_nxt[ps2kd_pkg::MB_LSHIFT] = 1'b0;
		if (mk == ps2kd_pkg::KEY_CTRL) begin
			mods_nxt[ps2kd_pkg::MB_LCTRL] = 1'b1;
			mods_nxt[ps2kd_pkg::MB_RCTRL] = 1'b1;
		end
		if (bk == ps2kd_pkg::KEY_CTRL) begin
			mods_nxt[ps2kd_pkg::MB_LCTRL] = 1'b0;
			mods_nxt[ps2kd_pkg::MB_RCTRL] = 1'b0;
		end
		if (mk == ps2kd_pkg::KEY_RSHIFT) mods_nxt[ps2kd_pkg::MB_RSHIFT] = 1'b1;
		if (bk == ps2kd_pkg::KEY_RSHIFT) mods_nxt[ps2kd_pkg::MB_RSHIFT] = 1'b0;
		if (mk == ps2kd_pkg::KEY_CAPS) begin
			mods_nxt[ps2kd_pkg::MB_CAPS] = !mods_q[ps2kd_pkg::MB_CAPS];
		end
		if (mk == ps2kd_pkg::KEY_NUM) begin
			mods_nxt[ps2kd_pkg::MB_NUM] = !mods_q[ps2kd_pkg::MB_NUM];
		end
		upper = mods_nxt[ps2kd_pkg::MB_CAPS] ^ mods_nxt[ps2kd_pkg::MB_LSHIFT];
		ch    = upper ? ps2kd_pkg::upper_rom(mk) : ps2kd_pkg::lower_rom(mk);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q  <= 8'h00;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mods_q  <= mods_nxt;
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			make_q  <= mk;
			break_q <= bk;
			ascii_q <= ch;
			flags_q <= mods_nxt;
		end
	end

	assign out_valid      = valid_q;
	assign make_key       = make_q;
	assign break_key      = break_q;
	assign ascii_char     = ascii_q;
	assign modifier_flags = flags_q;

endmodule

/* rtl/ps2_set2_key_decoder.sv */
`timescale 1ns / 1ps
// PS/2 set-2 key decoder: one result item per scancode byte, one item per cycle sustained while out_stall is low.
// An accepted byte is written into the queue and then into the result register, which drives out_valid.
// Throughput: one item per cycle while out_stall is low; a two-entry queue lets the classifier run ahead of a stall.
// Reset: arst_n clears the previous byte, all modifier flags, the queue and the result valid.
// Depends on ps2kd_pkg, ps2kd_front, ps2kd_queue and ps2kd_back.
module ps2_set2_key_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] make_key,
	output logic [7:0] break_key,
	output logic [7:0] ascii_char,
	output logic [7:0] modifier_flags
);

	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	ps2kd_pkg::item_t push_item;
	ps2kd_pkg::item_t head;

	ps2kd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.scan_byte (scan_byte),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	ps2kd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	ps2kd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.make_key       (make_key),
		.break_key      (break_key),
		.ascii_char     (ascii_char),
		.modifier_flags (modifier_flags)
	);

endmodule

/* rtl/ps2kd_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the PS/2 set-2 key decoder, bound to the top level.
// Depends on ps2_set2_key_decoder ports only.
module ps2kd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] make_key,
	input logic [7:0] break_key,
	input logic [7:0] ascii_char
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(make_key) && $stable(break_key))
		else $error("stalled result item changed");

	a_make_xor_break: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (make_key == 8'h00 || break_key == 8'h00))
		else $error("make and break reported together");

	a_ascii_needs_make: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && make_key == 8'h00 |-> ascii_char == 8'h00)
		else $error("ascii reported without a make code");

endmodule

bind ps2_set2_key_decoder ps2kd_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.make_key   (make_key),
	.break_key  (break_key),
	.ascii_char (ascii_char)
);
